// ===== hw/rtl/mmpbm_pkg.sv =====
// Package of the multimode PRG bank mapper: widths, codes, beat structs.
// Has no dependencies. Every RTL file of the mapper but mmpbm_ram imports it.
`default_nettype none

package mmpbm_pkg;

   localparam int unsigned ADDR_W      = 16;
   localparam int unsigned DATA_W      = 8;
   localparam int unsigned ROM_ADDR_W  = 20;
   localparam int unsigned CNT_W       = 7;
   localparam int unsigned BANK_W      = 6;
   localparam int unsigned OFFS_W      = 13;
   localparam int unsigned RAM_DEPTH   = 8192;
   localparam int unsigned MAX_BANKS   = 64;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned STEP_W      = $clog2(BANK_W + 1);

   // bus access codes
   localparam logic [1:0] REQ_CPU_READ  = 2'd0;
   localparam logic [1:0] REQ_CPU_WRITE = 2'd1;
   localparam logic [1:0] REQ_PPU_READ  = 2'd2;
   localparam logic [1:0] REQ_PPU_WRITE = 2'd3;

   // PRG modes from the latch write address
   localparam logic [1:0] MODE_32K          = 2'd0;
   localparam logic [1:0] MODE_UPPER_FIXED  = 2'd1;
   localparam logic [1:0] MODE_8K           = 2'd2;
   localparam logic [1:0] MODE_16K_MIRROR   = 2'd3;

   localparam logic [ADDR_W-1:0] PRG_RAM_BASE = 16'h6000;
   localparam logic [ADDR_W-1:0] ROM_BASE     = 16'h8000;
   localparam logic [ADDR_W-1:0] CHR_TOP      = 16'h1FFF;

   localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_BANKS);

   typedef struct packed {
      logic [1:0]        req_type;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } mmpbm_req_type;

   typedef struct packed {
      logic                  claimed;
      logic [DATA_W-1:0]     read_data;
      logic                  rom_read;
      logic [ROM_ADDR_W-1:0] rom_address;
      logic                  mirror_horizontal;
   } mmpbm_rsp_type;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_PRG_RD   = 3'd1,
      KIND_PRG_WR   = 3'd2,
      KIND_ROM_RD   = 3'd3,
      KIND_LATCH_WR = 3'd4,
      KIND_CHR_RD   = 3'd5,
      KIND_CHR_WR   = 3'd6
   } mmpbm_kind_type;

   typedef struct packed {
      mmpbm_kind_type    kind;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] data;
   } mmpbm_entry_type;

   typedef struct packed {
      logic            valid;
      mmpbm_entry_type entry;
   } mmpbm_queue_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mmpbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mmpbm_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mmpbm_front.sv =====
// Front of the mapper: takes request beats, decodes them, queues them.
// Depends on mmpbm_pkg.
`default_nettype none

module mmpbm_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire mmpbm_pkg::mmpbm_req_type  req_payload,
   input  wire logic                      hold,
   input  wire logic                      q_pop,
   output mmpbm_pkg::mmpbm_queue_type     q_head
);
   import mmpbm_pkg::*;

   mmpbm_entry_type   entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   mmpbm_kind_type    kind;
   logic              push_ok;
   logic              pop_ok;

   // decode the access
   always_comb begin
      kind = KIND_NONE;
      unique case (req_payload.req_type)
         REQ_CPU_READ: begin
            if (req_payload.address >= PRG_RAM_BASE) begin
               kind = (req_payload.address < ROM_BASE) ? KIND_PRG_RD : KIND_ROM_RD;
            end
         end
         REQ_CPU_WRITE: begin
            if (req_payload.address >= PRG_RAM_BASE) begin
               kind = (req_payload.address < ROM_BASE) ? KIND_PRG_WR : KIND_LATCH_WR;
            end
         end
         REQ_PPU_READ: begin
            if (req_payload.address <= CHR_TOP) begin
               kind = KIND_CHR_RD;
            end
         end
         REQ_PPU_WRITE: begin
            if (req_payload.address <= CHR_TOP) begin
               kind = KIND_CHR_WR;
            end
         end
         default: kind = KIND_NONE;
      endcase
   end

   assign req_full = hold || (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_pop && (cnt_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         entry_ff[wr_ptr_ff] <= '{kind: kind, address: req_payload.address,
                                  data: req_payload.write_data};
      end
   end

   assign q_head.valid = (cnt_ff != '0);
   assign q_head.entry = entry_ff[rd_ptr_ff];

   // queue never overfills
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("front queue count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/mmpbm_back.sv =====
// Back of the mapper: executes queued accesses, holds latch, RAMs and the
// bank-reduction sequencer, and the result register. Depends on mmpbm_pkg, mmpbm_ram.
`default_nettype none

module mmpbm_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire mmpbm_pkg::mmpbm_queue_type  q_head,
   output logic                             q_pop,
   output logic                             hold,
   input  wire logic [mmpbm_pkg::CNT_W-1:0] bank_count,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output mmpbm_pkg::mmpbm_rsp_type         rsp_payload
);
   import mmpbm_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type         st_ff, st_in;
   logic [OFFS_W-1:0] clr_ff, clr_in;
   mmpbm_kind_type    kind_ff, kind_in;
   logic [OFFS_W-1:0] offs_ff, offs_in;
   mmpbm_rsp_type     res_ff, res_in;
   mmpbm_rsp_type     out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] latch_data_ff, latch_data_in;
   logic [1:0]        latch_mode_ff, latch_mode_in;
   logic [BANK_W-1:0] rem_ff, rem_in;
   logic [BANK_W-1:0] dvd_ff, dvd_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic              low_ff, low_in;
   logic              zero_ff, zero_in;

   logic [BANK_W-1:0] bank16;
   logic              low_bit;
   logic [CNT_W-1:0]  trial;
   logic [BANK_W-1:0] rem_next;
   logic              take;
   logic [DATA_W-1:0] prg_q, chr_q;
   logic              prg_we, chr_we;
   logic [OFFS_W-1:0] prg_wa;
   logic [DATA_W-1:0] prg_wd;

   assign take  = (st_ff == ST_IDLE) && q_head.valid;
   assign q_pop = take;
   assign hold  = (st_ff == ST_CLEAR);

   // 16 KiB bank and the low 8 KiB bit for the current latch and window
   always_comb begin
      bank16  = latch_data_ff[BANK_W-1:0];
      low_bit = q_head.entry.address[13];
      unique case (latch_mode_ff)
         MODE_32K:         bank16 = {latch_data_ff[5:1], q_head.entry.address[14]};
         MODE_UPPER_FIXED: bank16 = q_head.entry.address[14] ?
                                    {latch_data_ff[5:3], 3'b111} : latch_data_ff[5:0];
         MODE_8K: begin
            bank16  = latch_data_ff[5:0];
            low_bit = latch_data_ff[7];
         end
         MODE_16K_MIRROR:  bank16 = latch_data_ff[5:0];
         default:          bank16 = latch_data_ff[5:0];
      endcase
   end

   // one restoring step of the bank reduction
   assign trial    = {rem_ff, dvd_ff[BANK_W-1]};
   assign rem_next = (trial >= div_ff) ? BANK_W'(trial - div_ff) : trial[BANK_W-1:0];

   always_comb begin
      st_in         = st_ff;
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      offs_in       = offs_ff;
      res_in        = res_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_pop;
      latch_data_in = latch_data_ff;
      latch_mode_in = latch_mode_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      step_in       = step_ff;
      div_in        = div_ff;
      low_in        = low_ff;
      zero_in       = zero_ff;
      unique case (st_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == OFFS_W'(RAM_DEPTH - 1)) begin
               st_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_head.valid) begin
               kind_in        = q_head.entry.kind;
               offs_in        = q_head.entry.address[OFFS_W-1:0];
               res_in         = '0;
               res_in.claimed = (q_head.entry.kind != KIND_NONE);
               st_in          = ST_DONE;
               case (q_head.entry.kind) inside
                  KIND_PRG_RD, KIND_CHR_RD: st_in = ST_READ;
                  KIND_ROM_RD: begin
                     dvd_in  = bank16;
                     rem_in  = '0;
                     step_in = STEP_W'(BANK_W);
                     div_in  = (bank_count > CNT_MAX) ? CNT_MAX : bank_count;
                     zero_in = (bank_count == '0);
                     low_in  = low_bit;
                     st_in   = ST_DIV;
                  end
                  KIND_LATCH_WR: begin
                     latch_data_in = q_head.entry.data;
                     latch_mode_in = q_head.entry.address[1:0];
                  end
                  default: st_in = ST_DONE;
               endcase
            end
         end
         ST_READ: begin
            res_in.read_data = (kind_ff == KIND_CHR_RD) ? chr_q : prg_q;
            st_in            = ST_DONE;
         end
         ST_DIV: begin
            rem_in  = rem_next;
            dvd_in  = dvd_ff << 1;
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               res_in.rom_read    = 1'b1;
               res_in.rom_address = zero_ff ? {{(BANK_W + 1){1'b0}}, offs_ff}
                                            : {rem_next, low_ff, offs_ff};
               st_in              = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_pop) begin
               out_in                   = res_ff;
               out_in.mirror_horizontal = latch_data_ff[6];
               out_valid_in             = 1'b1;
               st_in                    = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_CLEAR;
         clr_ff        <= '0;
         out_valid_ff  <= 1'b0;
         latch_data_ff <= '0;
         latch_mode_ff <= '0;
         step_ff       <= '0;
      end else begin
         st_ff         <= st_in;
         clr_ff        <= clr_in;
         out_valid_ff  <= out_valid_in;
         latch_data_ff <= latch_data_in;
         latch_mode_ff <= latch_mode_in;
         step_ff       <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      offs_ff <= offs_in;
      res_ff  <= res_in;
      out_ff  <= out_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
      low_ff  <= low_in;
      zero_ff <= zero_in;
   end

   // PRG-RAM: cleared after reset, then written by CPU
   assign prg_we = hold || (take && (q_head.entry.kind == KIND_PRG_WR));
   assign prg_wa = hold ? clr_ff : q_head.entry.address[OFFS_W-1:0];
   assign prg_wd = hold ? '0 : q_head.entry.data;
   assign chr_we = take && (q_head.entry.kind == KIND_CHR_WR);

   mmpbm_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_prg_ram (
      .clock   (clock),
      .wr_en   (prg_we),
      .wr_addr (prg_wa),
      .wr_data (prg_wd),
      .rd_en   (take && (q_head.entry.kind == KIND_PRG_RD)),
      .rd_addr (q_head.entry.address[OFFS_W-1:0]),
      .rd_data (prg_q)
   );

   mmpbm_ram #(.WIDTH(DATA_W), .DEPTH(RAM_DEPTH)) u_chr_ram (
      .clock   (clock),
      .wr_en   (chr_we),
      .wr_addr (q_head.entry.address[OFFS_W-1:0]),
      .wr_data (q_head.entry.data),
      .rd_en   (take && (q_head.entry.kind == KIND_CHR_RD)),
      .rd_addr (q_head.entry.address[OFFS_W-1:0]),
      .rd_data (chr_q)
   );

   assign rsp_empty   = !out_valid_ff;
   assign rsp_payload = out_ff;

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_CLEAR) |-> !q_pop)
      else $error("queue popped during PRG-RAM clear");

   a_step_live: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_DIV) |-> (step_ff != '0))
      else $error("bank reduction ran past its last step");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == ST_DIV) && !zero_ff) |-> ({1'b0, rem_ff} < div_ff))
      else $error("partial remainder not below bank count");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == ST_DONE) && !out_valid_ff) |=> (out_valid_ff && (st_ff == ST_IDLE)))
      else $error("finished result not moved to result register");

endmodule

`default_nettype wire

// ===== hw/rtl/multimode_prg_bank_mapper_unit.sv =====
// Top level of the multimode PRG bank mapper.
// Depends on mmpbm_pkg, mmpbm_front, mmpbm_back (and mmpbm_ram below it).
`default_nettype none

// Usage
//  - Request side is a queue write port: a beat goes in when req_push is high
//    and req_full is low. Each beat is one CPU or PPU bus access.
//  - Result side is a queue read port: while rsp_empty is low the oldest
//    result sits on rsp_payload; it leaves when rsp_pop is high.
//    Exactly one result beat comes back per request beat, in order.
//  - csr_* writes the 16 KiB bank count; csr_ready is always high. Write it
//    only while no access is in flight.
//  - Each access is taken from the queue in ST_IDLE; a RAM read then passes
//    ST_READ and a PRG-ROM read the bank reduction in ST_DIV, a restoring
//    modulo taking one bank bit per cycle; each then goes on through ST_DONE
//    into the result register. One access is executed at a time, so the next
//    beat is taken only once the last one has left ST_DONE.
//  - A two-entry queue sits between decode and execution, and a result
//    register at the output, so a stalled receiver does not block decode;
//    once the queue is full, req_full rises.
//  - After reset the PRG-RAM is swept to zero, one byte a cycle, and req_full
//    stays high until the sweep ends. Config writes are taken throughout.
//  - CHR-RAM is not cleared; a read of a byte never written is undefined.
module multimode_prg_bank_mapper_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire mmpbm_pkg::mmpbm_req_type    req_payload,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output mmpbm_pkg::mmpbm_rsp_type         rsp_payload,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [mmpbm_pkg::CNT_W-1:0] csr_data
);
   import mmpbm_pkg::*;

   mmpbm_queue_type  q_head;
   logic             q_pop;
   logic             hold;
   logic [CNT_W-1:0] count_ff, count_in;

   // bank count register: one beat, no index
   assign csr_ready = 1'b1;
   assign count_in  = (csr_valid && csr_ready) ? csr_data : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   mmpbm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .hold        (hold),
      .q_pop       (q_pop),
      .q_head      (q_head)
   );

   mmpbm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .hold        (hold),
      .bank_count  (count_ff),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== tb/sv/mmpbm_checker.sv =====
// Scoreboard for the multimode PRG bank mapper: watches request, result and CSR beats.
// Keeps its own copy of latch, RAMs and bank count, predicts each result, compares in order.
// Depends on mmpbm_pkg.
`timescale 1ns / 100ps

module mmpbm_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   input  wire logic                        req_full,
   input  wire mmpbm_pkg::mmpbm_req_type    req_payload,
   input  wire logic                        rsp_empty,
   input  wire logic                        rsp_pop,
   input  wire mmpbm_pkg::mmpbm_rsp_type    rsp_payload,
   input  wire logic                        csr_valid,
   input  wire logic                        csr_ready,
   input  wire logic [mmpbm_pkg::CNT_W-1:0] csr_data,
   output int                               fail_count,
   output int                               pending
);
   import mmpbm_pkg::*;

   logic [CNT_W-1:0]  bank_count;
   logic [DATA_W-1:0] latch_data;
   logic [1:0]        latch_mode;
   logic [DATA_W-1:0] prg_ram [RAM_DEPTH];
   logic [DATA_W-1:0] chr_ram [RAM_DEPTH];
   mmpbm_rsp_type     rsp_expected_q [$];
   int                mismatches = 0;

   // 8 KiB bank for a ROM read, reduced by the current 16 KiB bank count
   function automatic logic [6:0] rom_bank8(input logic [ADDR_W-1:0] addr);
      int unsigned cnt;
      int unsigned b16;
      int unsigned raw;
      cnt = (bank_count > CNT_MAX) ? MAX_BANKS : bank_count;
      if (cnt == 0)
         return '0;
      case (latch_mode)
         MODE_32K:         b16 = {latch_data[5:1], addr[14]};
         MODE_UPPER_FIXED: b16 = addr[14] ? {latch_data[5:3], 3'b111} : latch_data[5:0];
         MODE_8K: begin
            raw = {latch_data[5:0], latch_data[7]};
            return 7'(raw % (2 * cnt));
         end
         default:          b16 = latch_data[5:0];
      endcase
      return 7'((b16 % cnt) * 2 + addr[13]);
   endfunction

   // applies one access to the state and returns the result beat it should give
   function automatic mmpbm_rsp_type map_access(input mmpbm_req_type r);
      mmpbm_rsp_type o;
      o = '0;
      case (r.req_type)
         REQ_CPU_READ: if (r.address >= PRG_RAM_BASE) begin
            o.claimed = 1'b1;
            if (r.address < ROM_BASE) begin
               o.read_data = prg_ram[r.address[OFFS_W-1:0]];
            end else begin
               o.rom_read    = 1'b1;
               o.rom_address = {rom_bank8(r.address), r.address[OFFS_W-1:0]};
            end
         end
         REQ_CPU_WRITE: if (r.address >= PRG_RAM_BASE) begin
            o.claimed = 1'b1;
            if (r.address < ROM_BASE) begin
               prg_ram[r.address[OFFS_W-1:0]] = r.write_data;
            end else begin
               latch_data = r.write_data;
               latch_mode = r.address[1:0];
            end
         end
         REQ_PPU_READ: if (r.address <= CHR_TOP) begin
            o.claimed   = 1'b1;
            o.read_data = chr_ram[r.address[OFFS_W-1:0]];
         end
         default: if (r.address <= CHR_TOP) begin
            o.claimed = 1'b1;
            chr_ram[r.address[OFFS_W-1:0]] = r.write_data;
         end
      endcase
      o.mirror_horizontal = latch_data[6];
      return o;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      mmpbm_rsp_type want;
      if (reset) begin
         bank_count = CNT_RESET;
         latch_data = '0;
         latch_mode = MODE_32K;
         for (int i = 0; i < RAM_DEPTH; i++)
            prg_ram[i] = '0;
         rsp_expected_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            bank_count = csr_data;
         // result first: a result never belongs to a request taken on the same edge
         if (rsp_pop && !rsp_empty) begin
            if (rsp_expected_q.size() == 0) begin
               $error("result beat with no access outstanding");
               mismatches++;
            end else begin
               want = rsp_expected_q.pop_front();
               check_field("claimed", want.claimed, rsp_payload.claimed);
               check_field("read_data", want.read_data, rsp_payload.read_data);
               check_field("rom_read", want.rom_read, rsp_payload.rom_read);
               check_field("rom_address", want.rom_address, rsp_payload.rom_address);
               check_field("mirror_horizontal", want.mirror_horizontal,
                           rsp_payload.mirror_horizontal);
            end
         end
         if (req_push && !req_full)
            rsp_expected_q.push_back(map_access(req_payload));
      end
      fail_count <= mismatches;
      pending    <= rsp_expected_q.size();
   end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for multimode_prg_bank_mapper_unit: clock, reset, stimulus and verdict.
// Depends on mmpbm_pkg, the mapper RTL and mmpbm_checker, which does all the checking.
`timescale 1ns / 100ps

module tb_top;
   import mmpbm_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 300_000;
   localparam int unsigned PHASE_ITEMS   = 60;
   localparam int unsigned HOLD_CYCLES   = 400;

   logic             clock;
   logic             reset       = 1'b1;
   logic             req_push    = 1'b0;
   logic             req_full;
   mmpbm_req_type    req_payload = '0;
   logic             rsp_empty;
   logic             rsp_pop     = 1'b0;
   mmpbm_rsp_type    rsp_payload;
   logic             csr_valid   = 1'b0;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_data    = '0;
   int               fail_count;
   int               pending;

   // CHR bytes that have been written; reads only ever go to these
   bit               chr_seen [RAM_DEPTH];
   logic [ADDR_W-1:0] chr_addr_q [$];
   logic [ADDR_W-1:0] prg_addr_q [$];

   multimode_prg_bank_mapper_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   mmpbm_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic mmpbm_req_type bus_access(input logic [1:0] kind,
                                                input logic [ADDR_W-1:0] addr,
                                                input logic [DATA_W-1:0] data);
      mmpbm_req_type b;
      b.req_type   = kind;
      b.address    = addr;
      b.write_data = data;
      return b;
   endfunction

   // Random access, mostly decoded ones with random content; about one in ten
   // lands outside every window. CHR reads only hit bytes already written.
   function automatic mmpbm_req_type make_random_access();
      int unsigned  pick;
      logic [15:0]  r;
      logic [7:0]   d;
      pick = $urandom_range(0, 99);
      r    = 16'($urandom);
      d    = 8'($urandom);
      if (pick < 30)
         return bus_access(REQ_CPU_READ, {1'b1, r[14:0]}, d);
      if (pick < 45)
         return bus_access(REQ_CPU_WRITE, {1'b1, r[14:0]}, d);
      if (pick < 57)
         return bus_access(REQ_CPU_WRITE, PRG_RAM_BASE | r[12:0], d);
      if (pick < 69) begin
         if (prg_addr_q.size() != 0 && $urandom_range(0, 1) == 1)
            return bus_access(REQ_CPU_READ,
                              prg_addr_q[$urandom_range(0, prg_addr_q.size() - 1)], d);
         return bus_access(REQ_CPU_READ, PRG_RAM_BASE | r[12:0], d);
      end
      if (pick < 91) begin
         if (pick < 81 || chr_addr_q.size() == 0)
            return bus_access(REQ_PPU_WRITE, {3'b000, r[12:0]}, d);
         return bus_access(REQ_PPU_READ,
                           chr_addr_q[$urandom_range(0, chr_addr_q.size() - 1)], d);
      end
      // unmapped: CPU below the RAM window, PPU above the CHR window
      case ($urandom_range(0, 3))
         0:       return bus_access(REQ_CPU_READ, 16'($urandom_range(0, 16'h5FFF)), d);
         1:       return bus_access(REQ_CPU_WRITE, 16'($urandom_range(0, 16'h5FFF)), d);
         2:       return bus_access(REQ_PPU_READ, 16'($urandom_range(16'h2000, 16'hFFFF)), d);
         default: return bus_access(REQ_PPU_WRITE, 16'($urandom_range(16'h2000, 16'hFFFF)), d);
      endcase
   endfunction

   // Offers one beat and returns on the edge that takes it; push stays high
   // so back-to-back beats go without a bubble.
   task automatic send_access(input mmpbm_req_type beat);
      req_payload <= beat;
      req_push    <= 1'b1;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      if (beat.req_type == REQ_PPU_WRITE && beat.address <= CHR_TOP &&
          !chr_seen[beat.address[OFFS_W-1:0]]) begin
         chr_seen[beat.address[OFFS_W-1:0]] = 1'b1;
         chr_addr_q.push_back(beat.address);
      end
      if (beat.req_type == REQ_CPU_WRITE && beat.address >= PRG_RAM_BASE &&
          beat.address < ROM_BASE)
         prg_addr_q.push_back(beat.address);
   endtask

   // Bank count is only changed with nothing in flight; the task first lets the
   // outstanding count catch up with the beat taken on the current edge
   task automatic write_bank_count(input logic [CNT_W-1:0] value);
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Main stimulus: directed beats, then one random phase per bank count.
   initial begin : stimulus
      mmpbm_req_type    directed_q [$];
      logic [CNT_W-1:0] bank_settings [8];
      int unsigned      sent;
      int unsigned      burst;
      int unsigned      gap;

      bank_settings = '{7'd127, 7'd0, 7'd1, 7'd2, 7'd64, 7'd65,
                        7'($urandom_range(1, 64)), 7'($urandom_range(0, 127))};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // at the reset bank count: ROM top and swept PRG-RAM
      send_access(bus_access(REQ_CPU_READ, 16'hFFFF, 8'h00));
      send_access(bus_access(REQ_CPU_READ, 16'h6000, 8'h00));
      write_bank_count(7'd64);

      // each mode, window boundaries, RAM boundaries, unmapped sides, read data ignored
      directed_q.push_back(bus_access(REQ_CPU_WRITE, 16'h8000, 8'hFF));
      directed_q.push_back(bus_access(REQ_CPU_READ,  16'hE000, 8'h00));
      directed_q.push_back(bus_access(REQ_CPU_WRITE, 16'h8001, 8'hC5));
      directed_q.push_back(bus_access(REQ_CPU_READ,  16'h8000, 8'h00));
      directed_q.push_back(bus_access(REQ_CPU_READ,  16'hC000, 8'h00));
      directed_q.push_back(bus_access(REQ_CPU_WRITE, 16'hFFFE, 8'hBF));
      directed_q.push_back(bus_access(REQ_CPU_READ,  16'hA123, 8'h00));
      directed_q.push_back(bus_access(REQ_CPU_WRITE, 16'h8003, 8'h7F));
      directed_q.push_back(bus_access(REQ_CPU_READ,  16'hDFFF, 8'h00));
      directed_q.push_back(bus_access(REQ_CPU_WRITE, 16'h7FFF, 8'hA5));
      directed_q.push_back(bus_access(REQ_CPU_READ,  16'h7FFF, 8'hFF));
      directed_q.push_back(bus_access(REQ_CPU_WRITE, 16'h6000, 8'h5A));
      directed_q.push_back(bus_access(REQ_CPU_READ,  16'h6000, 8'h00));
      directed_q.push_back(bus_access(REQ_CPU_WRITE, 16'h5FFF, 8'hFF));
      directed_q.push_back(bus_access(REQ_CPU_READ,  16'h0000, 8'h00));
      directed_q.push_back(bus_access(REQ_CPU_READ,  16'h5FFF, 8'h00));
      directed_q.push_back(bus_access(REQ_PPU_WRITE, 16'h0000, 8'hFF));
      directed_q.push_back(bus_access(REQ_PPU_READ,  16'h0000, 8'h00));
      directed_q.push_back(bus_access(REQ_PPU_WRITE, 16'h1FFF, 8'h3C));
      directed_q.push_back(bus_access(REQ_PPU_READ,  16'h1FFF, 8'h00));
      directed_q.push_back(bus_access(REQ_PPU_WRITE, 16'h2000, 8'h11));
      directed_q.push_back(bus_access(REQ_PPU_READ,  16'hFFFF, 8'h00));
      foreach (directed_q[i])
         send_access(directed_q[i]);

      // random phases: bursts of random length, gaps mostly short, some none
      foreach (bank_settings[p]) begin
         write_bank_count(bank_settings[p]);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
               send_access(make_random_access());
               sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
               req_push <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      req_push <= 1'b0;

      // drain, then allow for the slowest access before the verdict
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Result side: stall segments of random length and random density, plus
   // two long hold-offs so the queue fills and req_full has to rise.
   initial begin : result_drain
      int unsigned seg_left;
      int unsigned stall_pct;
      int unsigned hold_left;
      int unsigned holds_left;
      int unsigned popped;
      int unsigned next_hold;

      seg_left   = 0;
      stall_pct  = 0;
      hold_left  = 0;
      holds_left = 2;
      popped     = 0;
      next_hold  = 100;
      forever begin
         @(posedge clock);
         if (rsp_pop && !rsp_empty)
            popped++;
         if (hold_left != 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (holds_left != 0 && popped >= next_hold) begin
            holds_left--;
            next_hold += 250;
            hold_left = HOLD_CYCLES;
            rsp_pop <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(1, 40);
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  2:       stall_pct = 50;
                  default: stall_pct = 90;
               endcase
            end
            seg_left--;
            rsp_pop <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Watchdog: covers the PRG-RAM sweep after reset and the slowest mix
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

endmodule

// ===== filelist.f =====
hw/rtl/mmpbm_pkg.sv
hw/rtl/mmpbm_ram.sv
hw/rtl/mmpbm_front.sv
hw/rtl/mmpbm_back.sv
hw/rtl/multimode_prg_bank_mapper_unit.sv
tb/sv/mmpbm_checker.sv
tb/sv/tb_top.sv
